// File: sv/sfm_pkg.sv
// Shared types and constants for the substring first-match search block.
// Item operation codes and the command/result groups between top and core.
// No dependencies.
package sfm_pkg;

   localparam int DATA_W = 8;
   localparam int POS_W  = 16;

   typedef enum logic [1:0] {
      OP_CLEAR    = 2'd0,
      OP_APPEND   = 2'd1,
      OP_HAYSTACK = 2'd2,
      OP_IDLE     = 2'd3
   } op_type;

   typedef struct packed {
      logic              valid;
      op_type            op;
      logic [DATA_W-1:0] data_byte;
      logic              last;
   } sfm_cmd_type;

   typedef struct packed {
      logic             valid;
      logic             found;
      logic [POS_W-1:0] position;
   } sfm_result_type;

endpackage

// File: sv/sfm_core.sv
// Search state and combinational match logic: needle and window shift lines,
// lane-parallel byte compare, fill/length/position counters.
// Depends on sfm_pkg.
module sfm_core
   import sfm_pkg::*;
#(
   parameter int MAX_NEEDLE    = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  sfm_cmd_type    cmd,
   output sfm_result_type result
);

   localparam int LEN_W = $clog2(MAX_NEEDLE + 1);
   localparam int EXT_W = POSITION_BITS + POS_W;
   localparam logic [LEN_W-1:0]         LEN_MAX  = LEN_W'(MAX_NEEDLE);
   localparam logic [POSITION_BITS-1:0] SEEN_MAX = '1;

   // index 0 holds the newest byte in both lines, so lane j lines up directly
   logic [DATA_W-1:0] needle_ff [MAX_NEEDLE];
   logic [DATA_W-1:0] window_ff [MAX_NEEDLE];
   logic [DATA_W-1:0] needle_shift [MAX_NEEDLE];
   logic [DATA_W-1:0] window_shift [MAX_NEEDLE];
   logic              needle_we;
   logic              window_we;

   logic [LEN_W-1:0]         len_ff, len_in;
   logic [LEN_W-1:0]         fill_ff, fill_in;
   logic [POSITION_BITS-1:0] seen_ff, seen_in;
   logic                     done_ff, done_in;

   logic [MAX_NEEDLE-1:0] lane_ok;
   logic [LEN_W-1:0]      fill_step;
   logic                  match_hit;
   logic [EXT_W-1:0]      start_ext;

   always_comb begin
      needle_shift[0] = cmd.data_byte;
      window_shift[0] = cmd.data_byte;
      for (int j = 1; j < MAX_NEEDLE; j++) begin
         needle_shift[j] = needle_ff[j-1];
         window_shift[j] = window_ff[j-1];
      end
      for (int j = 0; j < MAX_NEEDLE; j++) begin
         lane_ok[j] = (LEN_W'(j) >= len_ff) || (window_shift[j] == needle_ff[j]);
      end
   end

   assign fill_step = (fill_ff == LEN_MAX) ? fill_ff : fill_ff + 1'b1;
   assign match_hit = (fill_step >= len_ff) && (&lane_ok);
   assign start_ext = EXT_W'(seen_ff) - EXT_W'(len_ff) + EXT_W'(1);

   always_comb begin
      len_in          = len_ff;
      fill_in         = fill_ff;
      seen_in         = seen_ff;
      done_in         = done_ff;
      needle_we       = 1'b0;
      window_we       = 1'b0;
      result.valid    = 1'b0;
      result.found    = 1'b0;
      result.position = '0;
      if (cmd.valid) begin
         case (cmd.op)
            OP_CLEAR: begin
               len_in  = '0;
               fill_in = '0;
               seen_in = '0;
               done_in = 1'b0;
            end
            OP_APPEND: begin
               if (len_ff != LEN_MAX) begin
                  needle_we = 1'b1;
                  len_in    = len_ff + 1'b1;
               end
               fill_in = '0;
               seen_in = '0;
               done_in = 1'b0;
            end
            OP_HAYSTACK: begin
               if (!done_ff) begin
                  if (len_ff == '0) begin
                     result.valid = 1'b1;
                     result.found = 1'b1;
                  end else begin
                     window_we = 1'b1;
                     fill_in   = fill_step;
                     if (match_hit) begin
                        result.valid    = 1'b1;
                        result.found    = 1'b1;
                        result.position = start_ext[POS_W-1:0];
                     end else if (cmd.last) begin
                        result.valid = 1'b1;
                     end
                  end
                  done_in = result.valid;
                  if (seen_ff != SEEN_MAX) begin
                     seen_in = seen_ff + 1'b1;
                  end
               end
               if (cmd.last) begin
                  fill_in = '0;
                  seen_in = '0;
                  done_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         fill_ff <= '0;
         seen_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         len_ff  <= len_in;
         fill_ff <= fill_in;
         seen_ff <= seen_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (needle_we) begin
         needle_ff <= needle_shift;
      end
      if (window_we) begin
         window_ff <= window_shift;
      end
   end

endmodule

// File: sv/substring_first_match_top.sv
// Substring first-match search, top level: input register, search core, result register.
// Each item goes from the input register through the core to the result register.
// Throughput: one item per cycle into the core, except while rsp_stall holds a result.
// A held result stalls the input register only while rsp_stall is high.
// Synchronous active-high reset clears control state, needle length and search progress.
// Depends on sfm_pkg and sfm_core.
module substring_first_match_top
   import sfm_pkg::*;
#(
   parameter int MAX_NEEDLE    = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [DATA_W-1:0] req_data_byte,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [POS_W-1:0]  rsp_position
);

   logic              in_valid_ff, in_valid_in;
   logic [1:0]        in_op_ff;
   logic [DATA_W-1:0] in_data_ff;
   logic              in_last_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff;
   logic [POS_W-1:0]  rsp_position_ff;
   logic              advance;
   logic              req_take;
   sfm_cmd_type       cmd;
   sfm_result_type    result;

   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign cmd.valid     = in_valid_ff && advance;
   assign cmd.op        = op_type'(in_op_ff);
   assign cmd.data_byte = in_data_ff;
   assign cmd.last      = in_last_ff;

   sfm_core #(
      .MAX_NEEDLE    (MAX_NEEDLE),
      .POSITION_BITS (POSITION_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .result (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff && !advance;
      if (req_take) begin
         in_valid_in = 1'b1;
      end
      rsp_valid_in = advance ? result.valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_op_ff   <= req_operation;
         in_data_ff <= req_data_byte;
         in_last_ff <= req_last;
      end
      if (advance && result.valid) begin
         rsp_found_ff    <= result.found;
         rsp_position_ff <= result.position;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

endmodule

// File: sv/sfm_checker.sv
// Port-level checker for the substring first-match search block, bound to the top level.
// Depends on sfm_pkg.
module sfm_checker
   import sfm_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic [1:0]       req_operation,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_found,
   input logic [POS_W-1:0] rsp_position
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found) && $stable(rsp_position))
      else $error("result item changed while stalled");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("not-found item carries a nonzero position");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_needle_silent: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall &&
       (req_operation == OP_CLEAR || req_operation == OP_APPEND)) ##1 !rsp_stall
      |=> !rsp_valid)
      else $error("needle item produced a result");

endmodule

bind substring_first_match_top sfm_checker u_sfm_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_operation (req_operation),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_found     (rsp_found),
   .rsp_position  (rsp_position)
);

// File: bench/substring_first_match_checker.sv
`timescale 1ns / 100ps
// Result checker for substring_first_match_top: tracks the needle search on each accepted
// item, queues the expected found/position reports and compares accepted results in order.
// Depends on sfm_pkg.
module substring_first_match_checker
   import sfm_pkg::*;
#(
   parameter int MAX_NEEDLE    = 32,
   parameter int POSITION_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  logic [1:0]        req_operation,
   input  logic [DATA_W-1:0] req_data_byte,
   input  logic              req_last,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  logic              rsp_found,
   input  logic [POS_W-1:0]  rsp_position,
   output int                mismatch_count,
   output int                pending_reports
);

   localparam longint unsigned HASH_PRIME = 99991;
   localparam int              HASH_SHIFT = 7;
   localparam longint unsigned SEEN_MAX   = (64'd1 << POSITION_BITS) - 1;

   typedef struct {
      logic             found;
      logic [POS_W-1:0] position;
   } search_report_type;

   search_report_type expected_reports[$];

   logic [DATA_W-1:0] needle_bytes [MAX_NEEDLE];
   logic [DATA_W-1:0] recent_bytes [MAX_NEEDLE];
   int unsigned       needle_count;
   int unsigned       ring_wr;
   int unsigned       ring_count;
   longint unsigned   seen_count;
   longint unsigned   needle_sig;
   longint unsigned   window_sig;
   longint unsigned   lead_weight;
   bit                reported;

   initial begin
      mismatch_count  = 0;
      pending_reports = 0;
      for (int i = 0; i < MAX_NEEDLE; i++) begin
         recent_bytes[i] = '0;
         needle_bytes[i] = '0;
      end
   end

   task automatic restart_scan();
      seen_count = 0;
      window_sig = 0;
      reported   = 1'b0;
      ring_wr    = 0;
      ring_count = 0;
   endtask

   task automatic clear_needle();
      needle_count = 0;
      needle_sig   = 0;
      lead_weight  = 1;
      restart_scan();
   endtask

   task automatic advance_search(input op_type op, input logic [DATA_W-1:0] value,
                                 input logic is_last, output bit produced,
                                 output search_report_type report);
      longint unsigned sig;
      longint unsigned drop;
      longint unsigned start_at;
      int unsigned     oldest;
      int unsigned     first;
      bit              same;
      produced = 1'b0;
      report.found    = 1'b0;
      report.position = '0;
      case (op)
         OP_CLEAR: clear_needle();
         OP_APPEND: begin
            if (needle_count < MAX_NEEDLE) begin
               needle_bytes[needle_count] = value;
               needle_sig = ((needle_sig << HASH_SHIFT) + value) % HASH_PRIME;
               if (needle_count > 0)
                  lead_weight = (lead_weight << HASH_SHIFT) % HASH_PRIME;
               needle_count++;
            end
            restart_scan();
         end
         OP_HAYSTACK: begin
            if (!reported) begin
               if (needle_count == 0) begin
                  produced     = 1'b1;
                  report.found = 1'b1;
               end else begin
                  sig = window_sig;
                  if (ring_count >= needle_count) begin
                     oldest = (ring_wr + MAX_NEEDLE - needle_count) % MAX_NEEDLE;
                     drop   = (recent_bytes[oldest] * lead_weight) % HASH_PRIME;
                     sig    = (sig % HASH_PRIME + HASH_PRIME - drop) % HASH_PRIME;
                  end
                  window_sig = ((sig << HASH_SHIFT) + value) % HASH_PRIME;
                  recent_bytes[ring_wr] = value;
                  ring_wr = (ring_wr + 1) % MAX_NEEDLE;
                  if (ring_count < MAX_NEEDLE)
                     ring_count++;
                  if (ring_count >= needle_count && window_sig == needle_sig) begin
                     first = (ring_wr + MAX_NEEDLE - needle_count) % MAX_NEEDLE;
                     same  = 1'b1;
                     for (int k = 0; k < needle_count; k++) begin
                        if (recent_bytes[(first + k) % MAX_NEEDLE] != needle_bytes[k])
                           same = 1'b0;
                     end
                     if (same) begin
                        start_at        = seen_count - (needle_count - 1);
                        produced        = 1'b1;
                        report.found    = 1'b1;
                        report.position = start_at[POS_W-1:0];
                     end
                  end
                  if (!produced && is_last)
                     produced = 1'b1;
               end
               if (produced)
                  reported = 1'b1;
               if (seen_count < SEEN_MAX)
                  seen_count++;
            end
            if (is_last)
               restart_scan();
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      search_report_type want;
      bit                produced;
      if (reset) begin
         clear_needle();
         expected_reports.delete();
      end else begin
         if (req_valid && !req_stall) begin
            advance_search(op_type'(req_operation), req_data_byte, req_last, produced, want);
            if (produced)
               expected_reports = {expected_reports, want};
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected result: found %0d position %0d", rsp_found, rsp_position);
               mismatch_count++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_found !== want.found) begin
                  $error("found: expected %0d, got %0d", want.found, rsp_found);
                  mismatch_count++;
               end
               if (rsp_position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_position);
                  mismatch_count++;
               end
            end
         end
      end
      pending_reports = expected_reports.size();
   end

endmodule

// File: bench/substring_first_match_top_tb.sv
`timescale 1ns / 100ps
// Testbench top for substring_first_match_top: drives needle and haystack items with random
// gaps and result stalls, and reports the verdict from substring_first_match_checker.
// Depends on sfm_pkg, substring_first_match_top and substring_first_match_checker.
module substring_first_match_top_tb;
   import sfm_pkg::*;

   localparam int MAX_NEEDLE    = 32;
   localparam int RANDOM_ITEMS  = 600;
   localparam int HOLD_CYCLES   = 300;
   localparam int CYCLE_LIMIT   = 100000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [1:0]        req_operation;
   logic [DATA_W-1:0] req_data_byte;
   logic              req_last;
   logic              rsp_valid;
   logic              rsp_stall;
   logic              rsp_found;
   logic [POS_W-1:0]  rsp_position;

   int mismatch_count;
   int pending_reports;
   int cycle_count = 0;
   int items_sent  = 0;
   bit quiet       = 1'b0;
   bit hold_req    = 1'b0;

   substring_first_match_top uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_found     (rsp_found),
      .rsp_position  (rsp_position)
   );

   substring_first_match_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .mismatch_count  (mismatch_count),
      .pending_reports (pending_reports)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL substring_first_match_top");
         $finish;
      end
   end

   // result side: random stall after each accepted result, long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            stall_left = quiet ? 0 : $urandom_range(0, 13);
         @(negedge clock);
         if (hold_req) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req  = 1'b0;
            rsp_stall = 1'b0;
         end else if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   task automatic send_item(input op_type op, input logic [DATA_W-1:0] value,
                            input logic is_last);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_operation = op;
      req_data_byte = value;
      req_last      = is_last;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      if (op != OP_IDLE)
         items_sent++;
   endtask

   function automatic logic [DATA_W-1:0] pick_byte(input logic [DATA_W-1:0] base,
                                                   input bit narrow);
      logic [DATA_W-1:0] r;
      r = 8'($urandom_range(0, 255));
      if (narrow)
         r = base + r[0];
      return r;
   endfunction

   task automatic feed_haystack(input logic [DATA_W-1:0] pattern[$], input int hay_len,
                                input bit plant, input logic [DATA_W-1:0] base,
                                input bit narrow);
      logic [DATA_W-1:0] hay[$];
      int keep;
      int at;
      keep = (pattern.size() > MAX_NEEDLE) ? MAX_NEEDLE : pattern.size();
      for (int i = 0; i < hay_len; i++)
         hay = {hay, pick_byte(base, narrow)};
      if (plant && keep <= hay_len) begin
         at = $urandom_range(0, hay_len - keep);
         for (int k = 0; k < keep; k++)
            hay[at + k] = pattern[k];
      end
      for (int i = 0; i < hay_len; i++)
         send_item(OP_HAYSTACK, hay[i], i == hay_len - 1);
   endtask

   task automatic run_search(input int needle_len, input int hay_len);
      logic [DATA_W-1:0] pattern[$];
      logic [DATA_W-1:0] base;
      bit narrow;
      base   = 8'($urandom_range(0, 255));
      narrow = 1'($urandom_range(0, 1));
      quiet  = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < needle_len; i++)
         pattern = {pattern, pick_byte(base, narrow)};
      send_item(OP_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      foreach (pattern[i])
         send_item(OP_APPEND, pattern[i], 1'($urandom_range(0, 1)));
      feed_haystack(pattern, hay_len, $urandom_range(0, 2) != 0, base, narrow);
      // same needle, next search
      if ($urandom_range(0, 2) == 0)
         feed_haystack(pattern, $urandom_range(1, 12), 1'($urandom_range(0, 1)), base,
                       narrow);
   endtask

   initial begin
      int first_random;
      int choice;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_IDLE;
      req_data_byte = '0;
      req_last      = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty needle: first byte found at 0, rest of the search silent
      send_item(OP_HAYSTACK, 8'h00, 1'b0);
      send_item(OP_HAYSTACK, 8'hFF, 1'b1);
      send_item(OP_IDLE, 8'hFF, 1'b1);
      send_item(OP_APPEND, 8'h61, 1'b1);
      send_item(OP_APPEND, 8'h62, 1'b0);
      send_item(OP_HAYSTACK, 8'h00, 1'b0);
      send_item(OP_HAYSTACK, 8'h61, 1'b0);
      send_item(OP_HAYSTACK, 8'h62, 1'b0);
      send_item(OP_HAYSTACK, 8'h61, 1'b1);
      // haystack shorter than needle
      send_item(OP_HAYSTACK, 8'h61, 1'b1);
      // match on the last byte
      send_item(OP_HAYSTACK, 8'h61, 1'b0);
      send_item(OP_HAYSTACK, 8'h62, 1'b1);
      // append mid-search restarts the haystack
      send_item(OP_HAYSTACK, 8'h61, 1'b0);
      send_item(OP_APPEND, 8'h63, 1'b0);
      send_item(OP_HAYSTACK, 8'h61, 1'b0);
      send_item(OP_HAYSTACK, 8'h62, 1'b0);
      send_item(OP_HAYSTACK, 8'h63, 1'b1);
      send_item(OP_HAYSTACK, 8'hFF, 1'b0);
      send_item(OP_HAYSTACK, 8'h80, 1'b1);
      send_item(OP_CLEAR, 8'hFF, 1'b1);
      send_item(OP_HAYSTACK, 8'h80, 1'b1);

      // result side held off while one-byte searches keep coming
      wait (pending_reports == 0);
      @(negedge clock);
      quiet    = 1'b1;
      hold_req = 1'b1;
      repeat (24)
         send_item(OP_HAYSTACK, 8'($urandom_range(0, 255)), 1'b1);
      quiet = 1'b0;
      wait (pending_reports == 0);
      @(negedge clock);

      first_random = items_sent;
      // needle overflow and full-width window wrap
      run_search(34, 40);
      run_search(MAX_NEEDLE, 70);
      while (items_sent - first_random < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 9);
         if (choice < 7) begin
            run_search($urandom_range(0, 6), $urandom_range(1, 20));
         end else if (choice < 8) begin
            run_search($urandom_range(7, 34), $urandom_range(20, 70));
         end else begin
            quiet = 1'b0;
            repeat ($urandom_range(1, 8))
               send_item(op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
         end
      end

      req_valid = 1'b0;
      wait (pending_reports == 0);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0)
         $display("PASS substring_first_match_top");
      else
         $display("FAIL substring_first_match_top");
      $finish;
   end

endmodule
